>>> hw/rtl/bfiq_pkg.sv
// ============================================================================
// bfiq_pkg
// Shared constants, codes and controller/datapath interface types for the
// Bloom filter insert/query block.
// ============================================================================
`default_nettype none

package bfiq_pkg;

  // bit store
  localparam int MAX_BITS   = 1024;
  localparam int ADDR_W     = $clog2(MAX_BITS);
  localparam int SIZE_W     = ADDR_W + 1;

  // hashing
  localparam int MAX_HASHES = 3;
  localparam int CNT_W      = 2;

  // element and remainder unit
  localparam int ELEM_W     = 32;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = ELEM_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // configuration port
  localparam int BMS_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int CMP_W      = (BMS_W > SIZE_W) ? BMS_W : SIZE_W;

  // stream widths
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 8;

  localparam logic [BMS_W-1:0] RST_BITMAP_SIZE = BMS_W'(MAX_BITS);
  localparam logic [CNT_W-1:0] RST_HASH_COUNT  = CNT_W'(MAX_HASHES);

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BITMAP_SIZE = 1'b0,
    REG_HASH_COUNT  = 1'b1
  } cfg_reg_t;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DIV    = 6'b000100,
    S_HASH   = 6'b001000,
    S_CHECK  = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;      // take the input transfer
    logic div_step;  // one remainder step
    logic write;     // set bit at current index
    logic read;      // read bit at current index
    logic step;      // advance to next hash index
    logic check;     // fold read bit into answer
    logic out_load;  // move answer into output register
    logic clr_step;  // clear one store entry
  } dp_cmd_t;

  typedef struct packed {
    logic zero_count;
    logic in_query;
    logic is_query;
    logic last_hash;
    logic rd_bit;
    logic clr_last;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/bfiq_ram.sv
// ============================================================================
// bfiq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
`default_nettype none

module bfiq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bfiq_datapath.sv
// ============================================================================
// bfiq_datapath
// Config registers, magnitude/remainder unit, hash index stepping, bit store
// and output register.
// ============================================================================
`default_nettype none

module bfiq_datapath import bfiq_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic [IN_USER_W-1:0]  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat
);

  logic [BMS_W-1:0]  bitmap_size;
  logic [CNT_W-1:0]  hash_count;
  op_t               op;
  logic [ELEM_W-1:0] mag;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] idx;
  logic [CNT_W-1:0]  hnum;
  logic              present;
  logic [ADDR_W-1:0] clr_addr;
  logic              out_valid;
  logic              out_present;

  logic [SIZE_W-1:0] size;
  logic [ELEM_W-1:0] elem;
  logic [ELEM_W-1:0] mag_in;
  logic [SIZE_W-1:0] rem_next;
  logic [SIZE_W:0]   hsum;
  logic [SIZE_W-1:0] idx_next;
  logic              rd_bit;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;

  // zero size behaves as one, oversize saturates
  always_comb begin
    if (bitmap_size == '0) begin
      size = SIZE_W'(1);
    end else if (CMP_W'(bitmap_size) > CMP_W'(MAX_BITS)) begin
      size = SIZE_W'(MAX_BITS);
    end else begin
      size = SIZE_W'(bitmap_size);
    end
  end

  // -2^31 wraps to 0x80000000, which is its magnitude
  assign elem   = s_tdata[ELEM_W-1:0];
  assign mag_in = elem[ELEM_W-1] ? (~elem + ELEM_W'(1)) : elem;

  // restoring remainder, DIV_BITS bits of the magnitude per step
  always_comb begin
    logic [SIZE_W:0]   t;
    logic [SIZE_W-1:0] r;
    r = rem;
    t = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {r, mag[ELEM_W-1-k]};
      if (t >= {1'b0, size}) begin
        t = t - {1'b0, size};
      end
      r = t[SIZE_W-1:0];
    end
    rem_next = r;
  end

  // (m*(i+1)) mod s = ((m*i) mod s + m mod s) mod s
  always_comb begin
    hsum = {1'b0, idx} + {1'b0, rem};
    if (hsum >= {1'b0, size}) begin
      idx_next = SIZE_W'(hsum - {1'b0, size});
    end else begin
      idx_next = hsum[SIZE_W-1:0];
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap_size <= RST_BITMAP_SIZE;
      hash_count  <= RST_HASH_COUNT;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BITMAP_SIZE: bitmap_size <= cfg_data[BMS_W-1:0];
        REG_HASH_COUNT:  hash_count  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= op_t'(s_tuser[0]);
      mag     <= mag_in;
      rem     <= '0;
      hnum    <= CNT_W'(1);
      present <= 1'b1;
    end
    if (cmd.div_step) begin
      mag <= mag << DIV_BITS;
      rem <= rem_next;
      idx <= rem_next;
    end
    if (cmd.step) begin
      idx  <= idx_next;
      hnum <= hnum + CNT_W'(1);
    end
    if (cmd.check && !rd_bit) begin
      present <= 1'b0;
    end
    if (cmd.out_load) begin
      out_present <= present;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign ram_we    = cmd.clr_step | cmd.write;
  assign ram_waddr = cmd.clr_step ? clr_addr : idx[ADDR_W-1:0];

  bfiq_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (~cmd.clr_step),
    .rd_en   (cmd.read),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (rd_bit)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'(out_present);

  assign stat.zero_count = (hash_count == '0);
  assign stat.in_query   = (op_t'(s_tuser[0]) == OP_QUERY);
  assign stat.is_query   = (op == OP_QUERY);
  assign stat.last_hash  = (hnum == hash_count);
  assign stat.rd_bit     = rd_bit;
  assign stat.clr_last   = (clr_addr == ADDR_W'(MAX_BITS - 1));
  assign stat.out_busy   = out_valid & ~m_tready;

endmodule

`default_nettype wire

>>> hw/rtl/bfiq_ctrl.sv
// ============================================================================
// bfiq_ctrl
// Sequencer: store clear after reset, remainder steps, one store access per
// hash, result hand-off.
// ============================================================================
`default_nettype none

module bfiq_ctrl import bfiq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_CNT_W-1:0] div_cnt_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    div_cnt_next = div_cnt;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load     = 1'b1;
          div_cnt_next = '0;
          if (!stat.zero_count) begin
            state_next = S_DIV;
          end else if (stat.in_query) begin
            state_next = S_RESULT;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + DIV_CNT_W'(1);
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.is_query) begin
          cmd.read   = 1'b1;
          state_next = S_CHECK;
        end else begin
          cmd.write = 1'b1;
          cmd.step  = 1'b1;
          if (stat.last_hash) begin
            state_next = S_IDLE;
          end
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        cmd.step  = 1'b1;
        if (!stat.rd_bit || stat.last_hash) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_HASH;
        end
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bloom_filter_insert_query.sv
// ============================================================================
// bloom_filter_insert_query
// Bloom filter over a 1024-bit store, multiplicative hashes 1..hash_count.
// ============================================================================
// After reset the store is cleared one bit a cycle, so no input transfer is
// taken until the clear is done (config writes are taken throughout). Each
// item then runs alone: it is accepted, passes through the remainder unit
// (|element| mod bitmap_size, 4 bits a cycle), then gets one store write per
// hash for an insert, or a registered store read and a check per hash for a
// query, stopping at the first clear bit; a query then hands its answer to
// the output register once that register is free. Inserts give no output
// transfer; a query gives one. Config is to be written only while the block
// is idle.
`default_nettype none

module bloom_filter_insert_query import bfiq_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // config: index 0 bitmap_size, index 1 hash_count
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] element
  input  wire logic [IN_USER_W-1:0]  s_tuser,   // [0] op
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata    // [0] present, [7:1] zero
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bfiq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfiq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

>>> hw/rtl/bfiq_checker.sv
// ============================================================================
// bfiq_checker
// Port-level checks for the Bloom filter block, bound to the top level.
// ============================================================================
`default_nettype none

module bfiq_checker import bfiq_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic [IN_USER_W-1:0]  s_tuser,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  // store clear runs after reset; output starts empty
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("input taken or output valid straight after reset");

  // inserts never produce a transfer
  a_insert_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (op_t'(s_tuser[0]) == OP_INSERT) |=> !$rose(m_tvalid))
    else $error("output appeared after an insert");

  // a query answer cannot appear in the cycle after its input transfer
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !(m_tvalid && !$past(m_tvalid)))
    else $error("result faster than the block can compute it");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind bloom_filter_insert_query bfiq_checker u_bfiq_checker (.*);

`default_nettype wire
